// ----- design/lirl_pkg.sv -----
// Shared constants for the longest increasing run length block.
package lirl_pkg;

  localparam int MAX_LEN_DEF    = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int IN_VALUE_W     = 32;
  localparam int OUT_LEN_W      = 11;

endpackage

// ----- design/longest_increasing_run_length_top.sv -----
// Longest strictly increasing subsequence length over a stream of signed values.
//
// Input channel (in_valid/in_ready): one item per transfer carrying in_value,
// in_has_element and in_last. An element is stored in an internal memory
// with the length of the longest strictly increasing subsequence ending at it.
// An item with in_last ends the sequence and produces one result transfer on
// out_valid/out_ready carrying out_length and out_overflow. A bare end marker
// (in_has_element low, in_last high) on an empty sequence gives length 0.
// Elements beyond MAX_LEN are dropped and reported through out_overflow.
// Pacing: an element is compared with each held entry in turn through the
// single read port of the value/length memories, scanned one entry a cycle,
// and is written before the next input transfer is taken; items without an
// element return straight to idle, and a last item passes through the emit
// state. out_valid rises from the emit state, after a last element has been
// scanned and written, or directly after a bare end marker. The next item is
// accepted while a result waits; a last item that arrives while the earlier
// result is still stalled holds in the emit state until the receiver takes it.
// Reset (rst_n, synchronous): clears count, running best, overflow flag and
// the handshake state. The memories need no clearing; only entries written
// in the current sequence are read.
module longest_increasing_run_length_top #(
  parameter int MAX_LEN    = lirl_pkg::MAX_LEN_DEF,
  parameter int VALUE_BITS = lirl_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [lirl_pkg::IN_VALUE_W-1:0] in_value,
  input  logic                                  in_has_element,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [lirl_pkg::OUT_LEN_W-1:0] out_length,
  output logic                                  out_overflow
);
  import lirl_pkg::*;

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam logic [LEN_W-1:0] MAX_CNT = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] ONE     = LEN_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  state_t                        state_r;
  logic                          last_r;
  logic signed [VALUE_BITS-1:0]  key_r;
  logic        [LEN_W-1:0]       count_r;
  logic        [LEN_W-1:0]       best_r;
  logic                          ovf_r;
  logic        [LEN_W-1:0]       idx_r;
  logic                          rd_vld_r;
  logic        [LEN_W-1:0]       cand_r;
  logic                          out_valid_r;
  logic        [OUT_LEN_W-1:0]   out_length_r;
  logic                          out_overflow_r;

  logic signed [VALUE_BITS-1:0]  val_mem [MAX_LEN];
  logic        [LEN_W-1:0]       len_mem [MAX_LEN];
  logic signed [VALUE_BITS-1:0]  rd_val_r;
  logic        [LEN_W-1:0]       rd_len_r;

  logic                          in_xfer;
  logic                          issue;
  logic                          wr_en;
  logic                          out_free;
  logic        [LEN_W-1:0]       rd_len_inc;

  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign issue      = (state_r == S_SCAN) && (idx_r < count_r);
  assign wr_en      = (state_r == S_SCAN) && !issue && !rd_vld_r;
  assign out_free   = !out_valid_r || out_ready;
  assign rd_len_inc = rd_len_r + ONE;

  assign out_valid    = out_valid_r;
  assign out_length   = out_length_r;
  assign out_overflow = out_overflow_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[count_r[ADDR_W-1:0]] <= key_r;
      len_mem[count_r[ADDR_W-1:0]] <= cand_r;
    end
    rd_val_r <= val_mem[idx_r[ADDR_W-1:0]];
    rd_len_r <= len_mem[idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            key_r  <= VALUE_BITS'(in_value);
            last_r <= in_last;
            idx_r  <= '0;
            cand_r <= ONE;
            if (in_has_element && (count_r < MAX_CNT)) begin
              state_r <= S_SCAN;
            end else begin
              if (in_has_element) begin
                ovf_r <= 1'b1;
              end
              state_r <= in_last ? S_EMIT : S_IDLE;
            end
          end
        end
        S_SCAN: begin
          rd_vld_r <= issue;
          if (issue) begin
            idx_r <= idx_r + ONE;
          end
          if (rd_vld_r && (rd_val_r < key_r) && (rd_len_inc > cand_r)) begin
            cand_r <= rd_len_inc;
          end
          if (wr_en) begin
            count_r <= count_r + ONE;
            if (cand_r > best_r) begin
              best_r <= cand_r;
            end
            state_r <= last_r ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_length_r   <= OUT_LEN_W'(best_r);
            out_overflow_r <= ovf_r;
            count_r        <= '0;
            best_r         <= '0;
            ovf_r          <= 1'b0;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= MAX_CNT) && (best_r <= count_r))
    else $error("element count or best length out of range");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count_r < MAX_CNT) && (cand_r >= ONE) && (cand_r <= count_r + ONE))
    else $error("memory write beyond capacity or bad candidate length");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= count_r))
    else $error("scan index passed element count");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the longest increasing run length block.
`timescale 1ns / 100ps

module testbench;
  import lirl_pkg::*;

  localparam int IDLE_PCT     = 32;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 580;
  localparam int MAX_REPORTS  = 10;

  localparam logic [IN_VALUE_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
  localparam logic [IN_VALUE_W-1:0] MOST_POSITIVE = 32'h7fff_ffff;
  localparam int unsigned RAMP_STEP = 32'd4194304;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] length;
    logic                 overflow;
  } run_result_t;

  class run_length_board;
    logic signed [IN_VALUE_W-1:0] held_values [MAX_LEN_DEF];
    int unsigned held_lengths [MAX_LEN_DEF];
    int unsigned held_count;
    int unsigned best_run;
    bit          dropped;
    run_result_t awaited [$];
    int          errors;
    int          results;
    int          longest;
    int          overflow_results;

    function void note_item(logic signed [IN_VALUE_W-1:0] value, logic has_element,
                            logic last);
      int unsigned run;
      run_result_t res;
      if (has_element) begin
        if (held_count < MAX_LEN_DEF) begin
          run = 1;
          for (int j = 0; j < held_count; j++) begin
            if (held_values[j] < value && held_lengths[j] + 1 > run) begin
              run = held_lengths[j] + 1;
            end
          end
          held_values[held_count]  = value;
          held_lengths[held_count] = run;
          held_count++;
          if (run > best_run) best_run = run;
        end else begin
          dropped = 1'b1;
        end
      end
      if (last) begin
        res.length   = best_run[OUT_LEN_W-1:0];
        res.overflow = dropped;
        awaited.push_back(res);
        held_count = 0;
        best_run   = 0;
        dropped    = 1'b0;
      end
    endfunction

    function void check_result(logic [OUT_LEN_W-1:0] length, logic overflow);
      run_result_t want;
      results++;
      if (length > longest) longest = length;
      if (overflow) overflow_results++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected result %0d: length %0d overflow %0b", results, length, overflow);
        end
        return;
      end
      want = awaited.pop_front();
      if (length !== want.length || overflow !== want.overflow) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("result %0d: expected length %0d overflow %0b, got length %0d overflow %0b",
                   results, want.length, want.overflow, length, overflow);
        end
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [IN_VALUE_W-1:0] in_value;
  logic                         in_has_element;
  logic                         in_last;
  logic                         out_valid;
  logic                         out_ready;
  logic        [OUT_LEN_W-1:0]  out_length;
  logic                         out_overflow;

  run_length_board board;
  int  in_xfers;
  int  quiet_cycles;
  int  random_items;
  bit  steady;
  bit  hold_request;

  longest_increasing_run_length_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_has_element (in_has_element),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_length     (out_length),
    .out_overflow   (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      board.note_item(in_value, in_has_element, in_last);
      in_xfers++;
    end
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_length, out_overflow);
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, board.awaited.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // hold off the receiver so the block backs up
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_item(logic signed [IN_VALUE_W-1:0] value, logic has_element,
                           logic last);
    int target;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_value       <= value;
    in_has_element <= has_element;
    in_last        <= last;
    target = in_xfers + 1;
    do @(negedge clk); while (in_xfers < target);
  endtask

  function automatic logic signed [IN_VALUE_W-1:0] pick_value(int unsigned style);
    int unsigned choice;
    choice = (style == 3) ? $urandom_range(2) : style;
    case (choice)
      0: pick_value = $urandom_range(16) - 8;
      1: pick_value = $urandom;
      default: begin
        case ($urandom_range(3))
          0: pick_value = MOST_NEGATIVE;
          1: pick_value = MOST_POSITIVE;
          2: pick_value = -1;
          default: pick_value = 0;
        endcase
      end
    endcase
  endfunction

  task automatic send_sequence(int n);
    bit          end_marker;
    int unsigned style;
    end_marker = (n == 0) || ($urandom_range(2) == 0);
    style      = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) send_item($urandom, 1'b0, 1'b0);
      send_item(pick_value(style), 1'b1, !end_marker && (i == n - 1));
    end
    if (end_marker) send_item($urandom, 1'b0, 1'b1);
    random_items += n + int'(end_marker);
  endtask

  task automatic send_random(int target);
    int n;
    while (random_items < target) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(64) : $urandom_range(12);
      send_sequence(n);
    end
  endtask

  initial begin
    logic [IN_VALUE_W-1:0] ramp;
    board          = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_value       = '0;
    in_has_element = 1'b0;
    in_last        = 1'b0;
    steady         = 1'b0;
    hold_request   = 1'b0;
    in_xfers       = 0;
    quiet_cycles   = 0;
    random_items   = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // empty sequences, with and without a stray non-element first, then one- and two-element sequences
    send_item(0, 1'b0, 1'b1);
    send_item(MOST_POSITIVE, 1'b0, 1'b0);
    send_item(MOST_NEGATIVE, 1'b0, 1'b1);
    send_item(MOST_NEGATIVE, 1'b1, 1'b1);
    send_item(MOST_NEGATIVE, 1'b1, 1'b0);
    send_item(MOST_POSITIVE, 1'b1, 1'b1);
    // equal values do not extend a run, then a falling and a mixed sequence
    send_item(5, 1'b1, 1'b0);
    send_item(5, 1'b1, 1'b0);
    send_item(5, 1'b1, 1'b1);
    send_item(MOST_POSITIVE, 1'b1, 1'b0);
    send_item(0, 1'b1, 1'b0);
    send_item(MOST_NEGATIVE, 1'b1, 1'b1);
    send_item(-1, 1'b1, 1'b0);
    send_item(0, 1'b1, 1'b0);
    send_item(MOST_NEGATIVE, 1'b0, 1'b0);
    send_item(1, 1'b1, 1'b0);
    send_item(-2, 1'b1, 1'b0);
    send_item(MOST_POSITIVE, 1'b0, 1'b1);

    // fill to capacity with a strictly rising ramp, then overrun it
    for (int unsigned i = 0; i < MAX_LEN_DEF; i++) begin
      ramp = MOST_NEGATIVE + i * RAMP_STEP + $urandom_range(RAMP_STEP - 1);
      send_item(ramp, 1'b1, 1'b0);
    end
    send_item($urandom, 1'b1, 1'b0);
    send_item($urandom, 1'b1, 1'b1);

    send_random(RANDOM_ITEMS * 3 / 5);

    steady = 1'b1;
    send_random(RANDOM_ITEMS * 4 / 5);

    hold_request = 1'b1;
    for (int k = 0; k < 20; k++) send_sequence($urandom_range(3));
    steady = 1'b0;

    send_random(RANDOM_ITEMS);
    in_valid <= 1'b0;

    while (board.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d input transfers and %0d results checked, longest run %0d",
             in_xfers, board.results, board.longest);
    $display("%0d results flagged dropped elements, %0d mismatches, %0d results missing",
             board.overflow_results, board.errors, board.awaited.size());
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lirl_pkg.sv
design/longest_increasing_run_length_top.sv
sim/testbench.sv
